>>> hw/rtl/mthd_pkg.sv
// Shared constants and types for the median threshold hit detector.
package mthd_pkg;

	localparam int NUM_CH      = 10;
	localparam int COUNT_BITS  = 16;
	localparam int FIELD_CH    = 10;
	localparam int PWR_W       = 32;
	localparam int FUDGE_W     = 16;
	localparam int FRAC_W      = 8;
	localparam int RANK_W      = 4;
	localparam int PLAYER_W    = 4;
	localparam int CNT_OUT_W   = 16;
	localparam int CNT_W       = $clog2(NUM_CH + 1);
	localparam int IDX_W       = $clog2(NUM_CH);
	localparam int PROD_W      = PWR_W + FUDGE_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = FUDGE_W;
	localparam int IN_TDATA_W  = ((FIELD_CH * PWR_W + 7) / 8) * 8;
	localparam int OUT_BITS    = 1 + PLAYER_W + FIELD_CH * CNT_OUT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [FUDGE_W-1:0] FUDGE_RST = FUDGE_W'(2560);
	localparam logic [RANK_W-1:0]  RANK_RST  = RANK_W'(4);

	localparam logic [CFG_IDX_W-1:0] REG_FUDGE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANK  = CFG_IDX_W'(1);

	typedef enum logic {
		CMD_EVAL  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef logic [NUM_CH-1:0][PWR_W-1:0]      pwr_arr_t;
	typedef logic [NUM_CH-1:0][COUNT_BITS-1:0] cnt_arr_t;

	// Rank counts of one lane: values strictly below it, and values equal to it.
	typedef struct packed {
		logic [CNT_W-1:0] less;
		logic [CNT_W-1:0] eq;
	} lane_res_t;

	typedef lane_res_t [NUM_CH-1:0] lane_arr_t;

	// Control that goes with an item into the state update.
	typedef struct packed {
		logic             en;
		cmd_t             cmd;
		logic [IDX_W-1:0] win;
	} upd_t;

endpackage

>>> hw/rtl/mthd_lane.sv
// One rank lane: counts the channel powers below and equal to its own power.
module mthd_lane (
	input  logic [mthd_pkg::PWR_W-1:0] own,
	input  mthd_pkg::pwr_arr_t         pw,
	output mthd_pkg::lane_res_t        res
);

	always_comb begin
		res.less = '0;
		res.eq   = '0;
		for (int j = 0; j < mthd_pkg::NUM_CH; j++) begin
			if (pw[j] < own)
				res.less = res.less + mthd_pkg::CNT_W'(1);
			if (pw[j] == own)
				res.eq = res.eq + mthd_pkg::CNT_W'(1);
		end
	end

endmodule

>>> hw/rtl/mthd_merge.sv
// Merge of the lane ranks: median value, maximum value and winning channel.
module mthd_merge (
	input  mthd_pkg::lane_arr_t                lanes,
	input  mthd_pkg::pwr_arr_t                 pw,
	input  logic [mthd_pkg::RANK_W-1:0]        rank,
	output logic [mthd_pkg::PWR_W-1:0]         med,
	output logic [mthd_pkg::PWR_W-1:0]         max_val,
	output logic [mthd_pkg::IDX_W-1:0]         win
);

	logic [mthd_pkg::CNT_W:0] rank_sat;
	logic [mthd_pkg::CNT_W:0] lo;
	logic [mthd_pkg::CNT_W:0] hi;
	logic                     is_med;
	logic                     is_max;

	always_comb begin
		// Clamp the rank to the top position.
		if (rank > mthd_pkg::RANK_W'(mthd_pkg::NUM_CH - 1))
			rank_sat = (mthd_pkg::CNT_W + 1)'(mthd_pkg::NUM_CH - 1);
		else
			rank_sat = (mthd_pkg::CNT_W + 1)'(rank);
		med     = '0;
		max_val = '0;
		win     = '0;
		lo      = '0;
		hi      = '0;
		is_med  = 1'b0;
		is_max  = 1'b0;
		// A lane holds rank r when r falls in [less, less + eq); equal values share it.
		for (int i = 0; i < mthd_pkg::NUM_CH; i++) begin
			lo     = (mthd_pkg::CNT_W + 1)'(lanes[i].less);
			hi     = lo + (mthd_pkg::CNT_W + 1)'(lanes[i].eq);
			is_med = (lo <= rank_sat) && (rank_sat < hi);
			is_max = (hi == (mthd_pkg::CNT_W + 1)'(mthd_pkg::NUM_CH));
			if (is_med)
				med = med | pw[i];
			if (is_max) begin
				max_val = max_val | pw[i];
				win     = mthd_pkg::IDX_W'(i);
			end
		end
	end

endmodule

>>> hw/rtl/mthd_hit.sv
// Hit decision, saturating per-channel hit counters, sticky flag and last winner.
module mthd_hit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mthd_pkg::upd_t                  upd,
	input  logic [mthd_pkg::PWR_W-1:0]      max_val,
	input  logic [mthd_pkg::PROD_W-1:0]     thr,
	output logic                            flag_q,
	output logic [mthd_pkg::PLAYER_W-1:0]   player_q,
	output mthd_pkg::cnt_arr_t              counts_q
);

	logic [mthd_pkg::PROD_W-1:0] lhs;
	logic                        hit;

	always_comb begin
		lhs = mthd_pkg::PROD_W'({max_val, {mthd_pkg::FRAC_W{1'b0}}});
		hit = (upd.cmd == mthd_pkg::CMD_EVAL) && (lhs > thr) && (max_val != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q   <= 1'b0;
			player_q <= '0;
			counts_q <= '0;
		end else if (upd.en) begin
			if (upd.cmd == mthd_pkg::CMD_CLEAR) begin
				flag_q <= 1'b0;
			end else if (hit) begin
				flag_q   <= 1'b1;
				player_q <= mthd_pkg::PLAYER_W'(upd.win);
				if (counts_q[upd.win] != '1)
					counts_q[upd.win] <= counts_q[upd.win] + mthd_pkg::COUNT_BITS'(1);
			end
		end
	end

	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en |=> counts_q[$past(upd.win)] >= $past(counts_q[upd.win]))
		else $error("hit counter went down");

	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en && (upd.cmd == mthd_pkg::CMD_CLEAR) |=> !flag_q && $stable(counts_q)
			&& $stable(player_q))
		else $error("clear item changed counters or left flag set");

	a_flag_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flag_q) |-> $past(upd.en) && ($past(upd.cmd) == mthd_pkg::CMD_EVAL))
		else $error("flag set without an evaluate item");

	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		flag_q |-> counts_q[player_q[mthd_pkg::IDX_W-1:0]] != '0)
		else $error("flag set but winner counter is zero");

endmodule

>>> hw/rtl/median_threshold_hit_detector.sv
// Top level of the median threshold hit detector: pipeline, config and stream ports.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: cmd; tdata: power_0 .. power_9
//  m_      | out | m_tvalid/m_tready  | tdata: hit_flag, hit_player, count_0 .. count_9
//  cfg_    | in  | cfg_we             | cfg_idx 0 fudge_factor, 1 median_rank; cfg_data
//
// One item per cycle sustained while m_tready stays high; an accepted item passes the
// input register, then lane ranks, merge, multiply and the state update into the output.
// The state registers are the output register: they hold until the result is taken.
// Reset clears the pipeline valids, counters, flag and winner, and loads the
// config defaults. A stall at m_tready backs up stage by stage; bubbles collapse.
module median_threshold_hit_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mthd_pkg::IN_TDATA_W-1:0]       s_tdata,   // power_0 .. power_9, 32 bits each
	input  logic                                  s_tuser,   // cmd
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mthd_pkg::OUT_TDATA_W-1:0]      m_tdata,   // hit_flag, hit_player[4], count_0..9[16]
	input  logic                                  cfg_we,
	input  logic [mthd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [mthd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [mthd_pkg::FUDGE_W-1:0] fudge_q;
	logic [mthd_pkg::RANK_W-1:0]  rank_q;

	// Stage valids and stage advance.
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic rdy1, rdy2, rdy3, rdy4;

	// Stage 1: captured item.
	mthd_pkg::cmd_t     cmd_s1;
	mthd_pkg::pwr_arr_t pw_s1;

	// Stage 2: lane ranks.
	mthd_pkg::cmd_t      cmd_s2;
	mthd_pkg::pwr_arr_t  pw_s2;
	mthd_pkg::lane_arr_t lanes_c;
	mthd_pkg::lane_arr_t lanes_s2;

	// Stage 3: median, maximum and winner.
	logic [mthd_pkg::PWR_W-1:0] med_c, max_c;
	logic [mthd_pkg::IDX_W-1:0] win_c;
	mthd_pkg::cmd_t             cmd_s3;
	logic [mthd_pkg::PWR_W-1:0] med_s3, max_s3;
	logic [mthd_pkg::IDX_W-1:0] win_s3;

	// Stage 4: threshold product.
	mthd_pkg::cmd_t              cmd_s4;
	logic [mthd_pkg::PWR_W-1:0]  max_s4;
	logic [mthd_pkg::IDX_W-1:0]  win_s4;
	logic [mthd_pkg::PROD_W-1:0] thr_s4;

	// State seen on the output.
	mthd_pkg::upd_t                upd;
	logic                          flag_q;
	logic [mthd_pkg::PLAYER_W-1:0] player_q;
	mthd_pkg::cnt_arr_t            counts_q;

	// Config writes; software writes only while the pipeline is empty (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fudge_q <= mthd_pkg::FUDGE_RST;
			rank_q  <= mthd_pkg::RANK_RST;
		end else if (cfg_we) begin
			if (cfg_idx == mthd_pkg::REG_FUDGE)
				fudge_q <= cfg_data;
			if (cfg_idx == mthd_pkg::REG_RANK)
				rank_q <= cfg_data[mthd_pkg::RANK_W-1:0];
		end
	end

	// Each stage advances when it is empty or the one below moves on.
	always_comb begin
		rdy4     = !out_v_q || m_tready;
		rdy3     = !v_s4 || rdy4;
		rdy2     = !v_s3 || rdy3;
		rdy1     = !v_s2 || rdy2;
		s_tready = !v_s1 || rdy1;
		m_tvalid = out_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (rdy1)
				v_s2 <= v_s1;
			if (rdy2)
				v_s3 <= v_s2;
			if (rdy3)
				v_s4 <= v_s3;
			if (rdy4)
				out_v_q <= v_s4;
		end
	end

	// Capture the item; every power field maps to a channel.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= mthd_pkg::cmd_t'(s_tuser);
			for (int i = 0; i < mthd_pkg::NUM_CH; i++)
				pw_s1[i] <= s_tdata[i*mthd_pkg::PWR_W +: mthd_pkg::PWR_W];
		end
	end

	// One lane per channel ranks its power against all channel powers, its own included.
	for (genvar g = 0; g < mthd_pkg::NUM_CH; g++) begin : g_lane
		mthd_lane u_lane (
			.own (pw_s1[g]),
			.pw  (pw_s1),
			.res (lanes_c[g])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy1 && v_s1) begin
			cmd_s2   <= cmd_s1;
			pw_s2    <= pw_s1;
			lanes_s2 <= lanes_c;
		end
	end

	// Merge lane results into median, maximum and highest winning channel.
	mthd_merge u_merge (
		.lanes   (lanes_s2),
		.pw      (pw_s2),
		.rank    (rank_q),
		.med     (med_c),
		.max_val (max_c),
		.win     (win_c)
	);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s2) begin
			cmd_s3 <= cmd_s2;
			med_s3 <= med_c;
			max_s3 <= max_c;
			win_s3 <= win_c;
		end
	end

	// Threshold: median (Q16.16) times fudge factor (Q8.8), exact in Q24.24.
	always_ff @(posedge clk) begin
		if (rdy3 && v_s3) begin
			cmd_s4 <= cmd_s3;
			max_s4 <= max_s3;
			win_s4 <= win_s3;
			thr_s4 <= mthd_pkg::PROD_W'(med_s3) * mthd_pkg::PROD_W'(fudge_q);
		end
	end

	// Update the state as the item moves into the output slot.
	always_comb begin
		upd.en  = rdy4 && v_s4;
		upd.cmd = cmd_s4;
		upd.win = win_s4;
	end

	mthd_hit u_hit (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.max_val  (max_s4),
		.thr      (thr_s4),
		.flag_q   (flag_q),
		.player_q (player_q),
		.counts_q (counts_q)
	);

	// Pack the result; counters show their low 16 bits, pad bits read zero.
	always_comb begin
		m_tdata    = '0;
		m_tdata[0] = flag_q;
		m_tdata[1 +: mthd_pkg::PLAYER_W] = player_q;
		for (int k = 0; k < mthd_pkg::NUM_CH; k++)
			m_tdata[1 + mthd_pkg::PLAYER_W + k*mthd_pkg::CNT_OUT_W +: mthd_pkg::CNT_OUT_W] =
				mthd_pkg::CNT_OUT_W'(counts_q[k]);
	end

endmodule
